@@ sv/bacxh_pkg.sv @@
package bacxh_pkg;

   localparam int unsigned BlockBytes = 16;
   localparam int unsigned HalfBits   = 64;
   localparam int unsigned BlockBits  = 8 * BlockBytes;
   localparam int unsigned CountBits  = 5;
   localparam logic [7:0]  FeedbackInit = 8'hC9;
   localparam logic [CountBits-1:0] FullCount = 5'h10;

   typedef logic [7:0] byte_type;

   // One input word as it sits in the input register
   typedef struct packed {
      logic [BlockBits-1:0] block;
      logic [CountBits-1:0] byte_count;
      logic                 new_buffer;
      logic                 new_hash;
   } item_type;

   // Running hash state kept between words
   typedef struct packed {
      logic [BlockBits-1:0] hash;
      logic [BlockBits-1:0] pend_block;
      logic                 pend_full;
      byte_type             feedback;
      byte_type             round_count;
   } state_type;

endpackage

@@ sv/bacxh_absorb.sv @@
module bacxh_absorb (
   input  bacxh_pkg::item_type  item,
   input  bacxh_pkg::state_type cur,
   output bacxh_pkg::state_type nxt,
   output logic                 absorbed
);

   localparam int unsigned Bytes  = bacxh_pkg::BlockBytes;
   localparam int unsigned Levels = 4;

   bacxh_pkg::byte_type sum   [Bytes];
   bacxh_pkg::byte_type scan  [Levels+1][Bytes];
   bacxh_pkg::byte_type chain [Bytes];
   logic [bacxh_pkg::BlockBits-1:0] hash_start;
   logic [bacxh_pkg::BlockBits-1:0] hash_chain;
   logic                pend_start;
   bacxh_pkg::byte_type fb_start;
   bacxh_pkg::byte_type rc_start;
   bacxh_pkg::byte_type mix;
   logic                has_bytes;
   logic                is_full;

   // Apply hash clear and buffer restart ahead of the absorb
   always_comb begin
      hash_start = item.new_hash ? '0 : cur.hash;
      pend_start = item.new_buffer ? 1'b0 : cur.pend_full;
      fb_start   = item.new_buffer ? bacxh_pkg::FeedbackInit : cur.feedback;
      rc_start   = item.new_buffer ? 8'h00 : cur.round_count;
      has_bytes  = (item.byte_count != '0);
      is_full    = (item.byte_count >= bacxh_pkg::FullCount);
      absorbed   = has_bytes && pend_start;
   end

   // Add pending block bytes, then prefix-xor the sums with feedback in log steps
   always_comb begin
      for (int i = 0; i < Bytes; i++) begin
         sum[i] = hash_start[8*i +: 8] + cur.pend_block[8*i +: 8];
         scan[0][i] = (i == 0) ? (sum[i] ^ fb_start) : sum[i];
      end
      for (int l = 0; l < Levels; l++) begin
         for (int i = 0; i < Bytes; i++) begin
            if (i >= (1 << l)) begin
               scan[l+1][i] = scan[l][i] ^ scan[l][i - (1 << l)];
            end else begin
               scan[l+1][i] = scan[l][i];
            end
         end
      end
      for (int i = 0; i < Bytes; i++) begin
         chain[i] = scan[Levels][i];
         hash_chain[8*i +: 8] = chain[i];
      end
      mix = rc_start + chain[Bytes-1];
   end

   // Select the next state
   always_comb begin
      nxt.hash        = absorbed ? hash_chain : hash_start;
      nxt.feedback    = absorbed ? {mix[6:0], mix[7]} : fb_start;
      nxt.round_count = absorbed ? rc_start + 8'h01 : rc_start;
      nxt.pend_block  = cur.pend_block;
      nxt.pend_full   = pend_start;
      if (has_bytes) begin
         nxt.pend_full = is_full;
         if (is_full) begin
            nxt.pend_block = item.block;
         end
      end
   end

endmodule

@@ sv/block_add_xor_chain_hash.sv @@
// Block add/xor-chain hash.
// req_ channel: one 16-byte word per handshake (block_lo/hi, byte_count,
// new_buffer, new_hash). rsp_ channel: one word per request with the hash
// after that request and a flag telling whether the held block was absorbed.
// A full block is held and only enters the hash when a later word of the
// same buffer carries bytes; the last full block and short tails are dropped.
// An accepted word sits in the input register, is processed from there into
// the result register and shows on rsp_ from that register.
// Throughput: one word per cycle unless rsp_ready stalls the result; the add,
// xor chain and feedback update all fit between the input register and the
// result register, so words may follow back to back.
// Reset (synchronous, active high): hash cleared, nothing held, feedback
// 0xC9, round counter 0, both pipeline stages empty.
// Stall: when rsp_ready is low the result holds; one more word is still
// taken into the input register, after which req_ready drops.
module block_add_xor_chain_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_block_lo,
   input  logic [63:0] req_block_hi,
   input  logic [4:0]  req_byte_count,
   input  logic        req_new_buffer,
   input  logic        req_new_hash,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_lo,
   output logic [63:0] rsp_hash_hi,
   output logic        rsp_absorbed
);

   bacxh_pkg::item_type  item_ff, item_in;
   logic                 item_valid_ff, item_valid_in;
   bacxh_pkg::state_type state_ff, state_in;
   bacxh_pkg::state_type state_nxt;
   logic                 out_valid_ff, out_valid_in;
   logic [bacxh_pkg::BlockBits-1:0] out_hash_ff, out_hash_in;
   logic                 out_abs_ff, out_abs_in;
   logic                 abs_now;
   logic                 advance;
   logic                 req_fire;

   bacxh_absorb u_absorb (
      .item     (item_ff),
      .cur      (state_ff),
      .nxt      (state_nxt),
      .absorbed (abs_now)
   );

   // Handshake control
   always_comb begin
      advance   = !out_valid_ff || rsp_ready;
      req_ready = !item_valid_ff || advance;
      req_fire  = req_valid && req_ready;
   end

   // Load input register, advance state and result register
   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      state_in      = state_ff;
      out_valid_in  = out_valid_ff;
      out_hash_in   = out_hash_ff;
      out_abs_in    = out_abs_ff;
      if (advance) begin
         out_valid_in = item_valid_ff;
         if (item_valid_ff) begin
            state_in    = state_nxt;
            out_hash_in = state_nxt.hash;
            out_abs_in  = abs_now;
         end
         item_valid_in = 1'b0;
      end
      if (req_fire) begin
         item_valid_in      = 1'b1;
         item_in.block      = {req_block_hi, req_block_lo};
         item_in.byte_count = req_byte_count;
         item_in.new_buffer = req_new_buffer;
         item_in.new_hash   = req_new_hash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff        <= 1'b0;
         out_valid_ff         <= 1'b0;
         state_ff.hash        <= '0;
         state_ff.pend_block  <= '0;
         state_ff.pend_full   <= 1'b0;
         state_ff.feedback    <= bacxh_pkg::FeedbackInit;
         state_ff.round_count <= 8'h00;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
         state_ff      <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      out_hash_ff <= out_hash_in;
      out_abs_ff  <= out_abs_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_hash_lo  = out_hash_ff[bacxh_pkg::HalfBits-1:0];
   assign rsp_hash_hi  = out_hash_ff[bacxh_pkg::BlockBits-1:bacxh_pkg::HalfBits];
   assign rsp_absorbed = out_abs_ff;

endmodule

@@ sv/bacxh_checker.sv @@
module bacxh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_lo,
   input logic [63:0] rsp_hash_hi,
   input logic        rsp_absorbed
);

   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // A stalled result holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_lo)
         && $stable(rsp_hash_hi) && $stable(rsp_absorbed))
      else $error("stalled result word changed");

   // With the result stalled and the input register filled, back-pressure the input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(rsp_valid && !rsp_ready) && $past(req_valid && req_ready)
         && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted with both stages full");

endmodule

bind block_add_xor_chain_hash bacxh_checker u_bacxh_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_hash_lo  (rsp_hash_lo),
   .rsp_hash_hi  (rsp_hash_hi),
   .rsp_absorbed (rsp_absorbed)
);

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   localparam int CycleLimit   = 200000;
   localparam int RandomWords  = 700;
   localparam int LongHold     = 80;

   // One request word as the driver presents it
   typedef struct packed {
      logic [63:0]                     lo;
      logic [63:0]                     hi;
      logic [bacxh_pkg::CountBits-1:0] count;
      logic                            nb;
      logic                            nh;
   } req_word_type;

   // One expected response word
   typedef struct packed {
      logic [bacxh_pkg::BlockBits-1:0] hash;
      logic                            absorbed;
   } digest_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_block_lo = '0;
   logic [63:0] req_block_hi = '0;
   logic [4:0]  req_byte_count = '0;
   logic        req_new_buffer = 1'b0;
   logic        req_new_hash = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_hash_lo;
   logic [63:0] rsp_hash_hi;
   logic        rsp_absorbed;

   req_word_type word_q[$];
   digest_type   digest_q[$];
   req_word_type cur_word;
   digest_type   want;

   // Predictor state
   logic [bacxh_pkg::BlockBits-1:0] digest_sum = '0;
   logic [bacxh_pkg::BlockBits-1:0] held_blk = '0;
   logic                            held_full = 1'b0;
   bacxh_pkg::byte_type             chain_fb = bacxh_pkg::FeedbackInit;
   bacxh_pkg::byte_type             block_idx = '0;

   int  fail_count = 0;
   int  results_seen = 0;
   int  cycle_count = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  idle_n;
   bit  drv_quiet = 1'b0;
   bit  mon_quiet = 1'b0;

   block_add_xor_chain_hash uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_block_lo   (req_block_lo),
      .req_block_hi   (req_block_hi),
      .req_byte_count (req_byte_count),
      .req_new_buffer (req_new_buffer),
      .req_new_hash   (req_new_hash),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_lo    (rsp_hash_lo),
      .rsp_hash_hi    (rsp_hash_hi),
      .rsp_absorbed   (rsp_absorbed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none during a quiet stretch
   function automatic int pick_idle(input bit quiet);
      int r;
      r = $urandom_range(99);
      if (quiet || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Advance the hash for one accepted word and queue the expected response
   task automatic predict_digest(input req_word_type w);
      logic [bacxh_pkg::CountBits-1:0] n;
      bacxh_pkg::byte_type             t;
      digest_type                      d;
      n = (w.count > bacxh_pkg::FullCount) ? bacxh_pkg::FullCount : w.count;
      d.absorbed = 1'b0;
      if (w.nh)
         digest_sum = '0;
      if (w.nb) begin
         held_full = 1'b0;
         chain_fb  = bacxh_pkg::FeedbackInit;
         block_idx = '0;
      end
      if (n != 0) begin
         // absorb the held block: bytewise add, then xor chain
         if (held_full) begin
            for (int i = 0; i < bacxh_pkg::BlockBytes; i++)
               digest_sum[8*i +: 8] = digest_sum[8*i +: 8] + held_blk[8*i +: 8];
            digest_sum[7:0] = digest_sum[7:0] ^ chain_fb;
            for (int i = 1; i < bacxh_pkg::BlockBytes; i++)
               digest_sum[8*i +: 8] = digest_sum[8*i +: 8] ^ digest_sum[8*(i-1) +: 8];
            t = block_idx + digest_sum[bacxh_pkg::BlockBits-1 -: 8];
            chain_fb  = {t[6:0], t[7]};
            block_idx = block_idx + 8'd1;
            d.absorbed = 1'b1;
         end
         if (n == bacxh_pkg::FullCount) begin
            held_blk  = {w.hi, w.lo};
            held_full = 1'b1;
         end else begin
            held_full = 1'b0;
         end
      end
      d.hash = digest_sum;
      digest_q.push_back(d);
   endtask

   task automatic push_word(input logic [63:0] lo, input logic [63:0] hi,
                            input int count, input bit nb, input bit nh);
      req_word_type w;
      w.lo    = lo;
      w.hi    = hi;
      w.count = count[bacxh_pkg::CountBits-1:0];
      w.nb    = nb;
      w.nh    = nh;
      word_q.push_back(w);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Driver: hold the word until taken, then idle for its gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready)
            predict_digest(cur_word);
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (word_q.size() != 0) begin
            cur_word        = word_q.pop_front();
            req_block_lo   <= cur_word.lo;
            req_block_hi   <= cur_word.hi;
            req_byte_count <= cur_word.count;
            req_new_buffer <= cur_word.nb;
            req_new_hash   <= cur_word.nh;
            req_valid      <= 1'b1;
            gap_left       <= pick_idle(drv_quiet);
         end else begin
            req_valid <= 1'b0;
         end
         if ($urandom_range(63) == 0)
            drv_quiet <= !drv_quiet;
      end
   end

   // Monitor: check each response word and drive backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response: hash=%h_%h absorbed=%b",
                           rsp_hash_hi, rsp_hash_lo, rsp_absorbed);
            end else begin
               want = digest_q.pop_front();
               if (rsp_hash_lo !== want.hash[63:0] ||
                   rsp_hash_hi !== want.hash[bacxh_pkg::BlockBits-1:64] ||
                   rsp_absorbed !== want.absorbed) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch at response %0d", results_seen);
                     $display("  hash_lo  exp %h act %h", want.hash[63:0], rsp_hash_lo);
                     $display("  hash_hi  exp %h act %h",
                              want.hash[bacxh_pkg::BlockBits-1:64], rsp_hash_hi);
                     $display("  absorbed exp %b act %b", want.absorbed, rsp_absorbed);
                  end
               end
            end
         end

         // long hold-off at two points to fill the pipeline and stall the input
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready && (results_seen == 100 || results_seen == 450)) begin
            hold_left <= LongHold;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            idle_n = pick_idle(mon_quiet);
            stall_left <= idle_n;
            rsp_ready  <= (idle_n == 0);
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= (stall_left == 1);
         end else begin
            rsp_ready <= 1'b1;
         end

         if (rsp_valid && rsp_ready)
            results_seen++;
         if ($urandom_range(63) == 0)
            mon_quiet <= !mon_quiet;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int len;
      int target;
      bit fresh;

      // Directed: extremes of data and count, flag combinations, corner cases
      push_word('0, '0, 16, 1, 1);
      push_word('1, '1, 16, 0, 0);
      push_word('1, '1, 16, 0, 0);
      push_word(rand64(), rand64(), 0, 0, 0);      // no bytes: keep held block
      push_word(rand64(), rand64(), 16, 0, 0);
      push_word(rand64(), rand64(), 16, 0, 1);     // clear hash, held block still absorbed
      push_word(rand64(), rand64(), 31, 0, 0);     // count above 16 acts as full
      push_word(rand64(), rand64(), 17, 0, 0);
      push_word(rand64(), rand64(), 15, 0, 0);     // short tail absorbs, holds nothing
      push_word(rand64(), rand64(), 16, 0, 0);     // after tail: nothing absorbed
      push_word(rand64(), rand64(), 16, 1, 0);     // new buffer drops held block
      push_word(rand64(), rand64(), 1, 0, 0);
      push_word(rand64(), rand64(), 0, 1, 1);      // flags act without bytes
      push_word('1, '1, 16, 0, 0);
      push_word('0, '0, 0, 0, 0);
      push_word('1, '1, 16, 0, 0);
      push_word('1, '1, 8, 0, 0);
      push_word(rand64(), rand64(), 16, 1, 0);
      push_word(rand64(), rand64(), 2, 1, 0);      // new buffer with a short word

      // One long buffer so the block counter wraps
      target = word_q.size() + RandomWords;
      for (int k = 0; k < 270; k++)
         push_word(rand64(), rand64(), 16, k == 0, k == 0);

      // Random buffers with some noise words in between
      while (word_q.size() < target) begin
         if ($urandom_range(99) < 15) begin
            push_word(rand64(), rand64(), $urandom_range(0, 31),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            len   = $urandom_range(1, 10);
            fresh = ($urandom_range(3) != 0);
            for (int k = 0; k < len; k++)
               push_word(rand64(), rand64(), 16, k == 0,
                         (k == 0) ? fresh : ($urandom_range(19) == 0));
            if ($urandom_range(1) != 0)
               push_word(rand64(), rand64(), $urandom_range(1, 15), 0, 0);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Drain: all words sent and every response seen
      do
         @(negedge clock);
      while (word_q.size() != 0 || req_valid || digest_q.size() != 0);
      repeat (8) @(posedge clock);

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
